/* rtl/core/siq_pkg.sv */
// Shared types and constants for the sorted insert queue.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package siq_pkg;

    // Number of entries the queue holds.
    localparam int CAPACITY = 16;
    // Width of the entry count, wide enough to hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DATA_W = 32;

    // Request opcodes.
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_POP = 2'd2;
    localparam logic [1:0] OP_PEEK = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Ordered insert rules.
    localparam logic [1:0] MODE_ASC = 2'd0;
    localparam logic [1:0] MODE_DESC = 2'd1;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0] count_t;

    // Control broadcast from the top level to every cell of the row.
    typedef struct packed {
        logic       write;
        logic       ordered;
        logic       pop;
        logic [1:0] mode;
        data_t      data;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/siq_if.sv */
// Valid/ready channel interfaces for the sorted insert queue.
// Depends on siq_pkg for the payload types.
`default_nettype none

interface siq_cmd_if;
    import siq_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    data_t      data_value;

    modport source (output valid, output opcode, output data_value, input ready);
    modport sink (input valid, input opcode, input data_value, output ready);
endinterface

interface siq_rsp_if;
    import siq_pkg::*;

    logic       valid;
    logic       ready;
    data_t      head_value;
    logic [1:0] status;
    count_t     entry_count;

    modport source (output valid, output head_value, output status, output entry_count,
                    input ready);
    modport sink (input valid, input head_value, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/siq_cell.sv */
// One storage cell of the queue row: holds one entry and decides whether the
// new value lands here, the entry shifts toward the tail, or it moves toward the head.
// Depends on siq_pkg.
`default_nettype none

module siq_cell (
    input  wire logic              clk,
    input  wire siq_pkg::cell_ctl_t ctl,
    input  wire logic              occupied,
    input  wire logic              at_tail,
    input  wire logic              found_in,
    input  wire siq_pkg::data_t    left_value,
    input  wire siq_pkg::data_t    right_value,
    output logic                   found_out,
    output siq_pkg::data_t         value
);
    import siq_pkg::*;

    data_t value_reg;
    data_t value_next;
    logic  match;
    logic  here;

    // The new value belongs ahead of this entry when the order rule says so.
    assign match = ctl.ordered && occupied &&
                   (((ctl.mode == MODE_ASC) && (ctl.data <= value_reg)) ||
                    ((ctl.mode == MODE_DESC) && (ctl.data > value_reg)));
    assign here = !found_in && (match || at_tail);
    assign found_out = found_in || here;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.write)
        begin
            if (found_in)
            begin
                value_next = left_value;
            end
            else if (here)
            begin
                value_next = ctl.data;
            end
        end
        else if (ctl.pop)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

/* rtl/core/sorted_insert_queue.sv */
// Sorted insert queue: a bounded queue of signed 32-bit values in a row of cells.
// Each result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the result port takes each result;
// the insert position ripples through the CAPACITY-cell row inside that cycle.
// Reset (rst_n low, asynchronous): queue empty, order_mode ascending, no result pending.
// Entry storage is not cleared; only entries below the count are ever compared or returned.
`default_nettype none

module sorted_insert_queue (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_we,
    input  wire logic [1:0] cfg_wdata,
    siq_cmd_if.sink     cmd,
    siq_rsp_if.source   rsp
);
    import siq_pkg::*;

    // Configuration: the rule used by ordered inserts.
    logic [1:0] order_mode_reg;

    // Number of entries currently held.
    count_t occupancy_reg;
    count_t occupancy_next;

    // Registered result, held until the consumer takes it.
    logic   rsp_valid_reg;
    data_t  head_reg;
    logic [1:0] status_reg;
    count_t count_reg;

    logic   accept;
    logic   is_enq;
    logic   is_deq;
    logic   full;
    logic   empty;
    data_t  head_next;
    logic [1:0] status_next;
    cell_ctl_t ctl;

    // Row wiring: each cell sees its neighbors' entries and the insert-found chain.
    data_t  cell_value [CAPACITY];
    logic   found [CAPACITY+1];

    // A request is taken whenever the result register is free or being emptied.
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept = cmd.valid && cmd.ready;

    assign is_enq = (cmd.opcode == OP_PUSH) || (cmd.opcode == OP_INSERT);
    assign is_deq = (cmd.opcode == OP_POP) || (cmd.opcode == OP_PEEK);
    assign full = (occupancy_reg == CNT_W'(CAPACITY));
    assign empty = (occupancy_reg == '0);

    // Broadcast control. A push behaves like an insert that matches nowhere,
    // so the value lands at the first free cell.
    always_comb
    begin
        ctl.write = accept && is_enq && !full;
        ctl.ordered = (cmd.opcode == OP_INSERT);
        ctl.pop = accept && (cmd.opcode == OP_POP) && !empty;
        ctl.mode = order_mode_reg;
        ctl.data = cmd.data_value;
    end

    assign found[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        data_t left_v;
        data_t right_v;

        // The head cell never takes from the left and the last cell never
        // takes from the right; their own entry stands in for the missing neighbor.
        if (i == 0)
        begin : g_first
            assign left_v = cell_value[i];
        end
        else
        begin : g_mid_l
            assign left_v = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = cell_value[i];
        end
        else
        begin : g_mid_r
            assign right_v = cell_value[i+1];
        end

        siq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (CNT_W'(i) < occupancy_reg),
            .at_tail     (CNT_W'(i) == occupancy_reg),
            .found_in    (found[i]),
            .left_value  (left_v),
            .right_value (right_v),
            .found_out   (found[i+1]),
            .value       (cell_value[i])
        );
    end

    // Count and result for the accepted request.
    always_comb
    begin
        occupancy_next = occupancy_reg;
        head_next = '0;
        status_next = ST_DONE;
        if (is_enq)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                occupancy_next = occupancy_reg + CNT_W'(1);
            end
        end
        else if (is_deq)
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                head_next = cell_value[0];
                if (cmd.opcode == OP_POP)
                begin
                    occupancy_next = occupancy_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= MODE_ASC;
            occupancy_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                order_mode_reg <= cfg_wdata;
            end
            if (accept)
            begin
                occupancy_reg <= occupancy_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by rsp_valid_reg.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_reg <= head_next;
            status_reg <= status_next;
            count_reg <= occupancy_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.head_value = head_reg;
    assign rsp.status = status_reg;
    assign rsp.entry_count = count_reg;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy_reg <= CNT_W'(CAPACITY))
        else $error("occupancy exceeds capacity");

    // A full report leaves the queue at capacity with a zero value.
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == ST_FULL)) |->
        ((count_reg == CNT_W'(CAPACITY)) && (head_reg == '0)))
        else $error("full status with wrong count or value");

    // An empty report only comes with an empty queue.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == ST_EMPTY)) |-> (count_reg == '0))
        else $error("empty status with nonzero count");

    // A successful pop drops the count by one.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |=> (occupancy_reg == $past(occupancy_reg) - CNT_W'(1)))
        else $error("pop did not decrement occupancy");

    // The registered count always tracks the live occupancy after an accept.
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg == occupancy_reg))
        else $error("result count differs from occupancy");

endmodule

`default_nettype wire
